@@ rtl/core/lrct_pkg.sv @@
// Package for the LED ring countdown timer: constants, mode codes, gamma ROM.
// No dependencies.
package lrct_pkg;
    localparam int RingLeds = 12;
    localparam int LedW = 5;
    localparam int PixW = 4;
    localparam int ShadeTop = 8;
    localparam int BrightRows = 17;
    localparam int QDepth = 4;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_DOWN = 3'd1;
    localparam logic [2:0] MODE_ALERT = 3'd2;
    localparam logic [2:0] MODE_UP = 3'd3;
    localparam logic [2:0] MODE_SETT = 3'd4;
    localparam logic [2:0] MODE_SETA = 3'd5;

    localparam logic [1:0] REG_TPLED = 2'd0;
    localparam logic [1:0] REG_TPLVL = 2'd1;
    localparam logic [1:0] REG_FLASH = 2'd2;
    localparam logic [1:0] REG_TMO = 2'd3;

    typedef struct packed {
        logic start;
        logic add;
        logic long_add;
    } t_tick;

    typedef logic [23:0] t_pix;

    function automatic logic [7:0] gamma(input logic [4:0] row_in, input logic [3:0] col_in);
        logic [4:0] r;
        logic [3:0] c;
        logic [7:0] t [0:152];
        r = (row_in > 5'd16) ? 5'd16 : row_in;
        c = (col_in > 4'd8) ? 4'd8 : col_in;
        t = '{
            0,1,1,2,2,3,3,4,4,
            0,1,2,3,4,5,6,7,8,
            0,1,2,3,4,6,8,10,12,
            0,1,2,4,6,9,11,14,18,
            0,1,2,4,7,10,15,20,26,
            0,1,3,5,9,14,20,27,35,
            0,1,4,7,12,18,26,35,46,
            0,1,4,9,15,23,33,44,58,
            0,1,3,8,15,25,38,54,73,
            0,1,4,9,18,30,46,65,89,
            0,1,4,11,22,36,55,79,107,
            0,1,5,13,26,43,65,93,126,
            0,1,6,16,30,50,76,109,148,
            0,1,7,18,35,58,89,127,172,
            0,2,8,21,40,67,102,145,197,
            0,2,9,24,46,76,116,166,225,
            0,2,11,27,52,87,132,188,255};
        return t[8'(r) * 8'd9 + 8'(c)];
    endfunction
endpackage

@@ rtl/core/lrct_if.sv @@
// Valid/ready channel interfaces for ticks, pixels and configuration writes.
// No dependencies.
interface lrct_tick_if;
    logic valid;
    logic ready;
    logic start_pressed;
    logic add_pressed;
    logic add_long_pressed;
    modport source(output valid, start_pressed, add_pressed, add_long_pressed, input ready);
    modport sink(input valid, start_pressed, add_pressed, add_long_pressed, output ready);
endinterface

interface lrct_pix_if;
    logic valid;
    logic ready;
    logic [3:0] pixel_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic last_pixel;
    logic [2:0] mode_now;
    modport source(output valid, pixel_index, red_level, green_level, blue_level, last_pixel,
                   mode_now, input ready);
    modport sink(input valid, pixel_index, red_level, green_level, blue_level, last_pixel,
                 mode_now, output ready);
endinterface

interface lrct_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/lrct_queue.sv @@
// Short tick queue between the front and back halves.
// Depends on lrct_pkg.
module lrct_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lrct_pkg::t_tick   i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output lrct_pkg::t_tick   o_data
);
    localparam int AW = $clog2(lrct_pkg::QDepth);
    lrct_pkg::t_tick r_mem [lrct_pkg::QDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;

    assign o_full = (r_cnt == (AW+1)'(lrct_pkg::QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

@@ rtl/core/lrct_engine.sv @@
// Back half: runs the mode controller per tick, then streams the frame out when the ring changes.
// Depends on lrct_pkg and lrct_if.
module lrct_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lrct_pkg::t_tick   i_tick,
    output logic              o_pop,
    input  logic [31:0]       i_tpled,
    input  logic [28:0]       i_tplvl,
    input  logic [15:0]       i_flash,
    input  logic [31:0]       i_tmo,
    output logic              o_busy,
    lrct_pix_if.source        pix
);
    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_MUL = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0] r_st, n_st;
    logic [2:0] r_mode, n_mode;
    logic [4:0] r_lit, n_lit;
    logic [3:0] r_shade, n_shade;
    logic [31:0] r_tick, n_tick, r_lvl, n_lvl, r_total;
    logic [4:0] r_tsel, n_tsel, r_asel, n_asel;
    logic r_phase, n_phase;
    lrct_pkg::t_pix r_pix [lrct_pkg::RingLeds];
    lrct_pkg::t_pix n_pix [lrct_pkg::RingLeds];
    logic [4:0] r_mul_a, n_mul_a;
    logic n_mul;
    logic [3:0] r_idx;
    logic show;
    logic [63:0] prod;

    assign prod = 64'(r_mul_a) * 64'(i_tpled);

    function automatic logic [4:0] bump(input logic [4:0] s_in, input logic up);
        logic [4:0] s;
        s = (s_in > 5'd16) ? 5'd16 : s_in;
        if (up) return (s == 5'd16) ? 5'd0 : s + 5'd1;
        return (s == 5'd0) ? 5'd16 : s - 5'd1;
    endfunction

    always_comb begin
        logic st, ad, lg, both, hit;
        logic [31:0] lvl;
        logic [7:0] v;
        st = i_tick.start; ad = i_tick.add; lg = i_tick.long_add;
        both = st && ad;
        n_mode = r_mode; n_lit = r_lit; n_shade = r_shade; n_tick = r_tick; n_lvl = r_lvl;
        n_tsel = r_tsel; n_asel = r_asel; n_phase = r_phase; n_pix = r_pix;
        n_mul_a = r_mul_a; n_mul = 1'b0; show = 1'b0; hit = 1'b0; v = '0;
        lvl = (i_tplvl == '0) ? 32'd1 : 32'(i_tplvl);
        if (r_mode >= lrct_pkg::MODE_DOWN && r_mode <= lrct_pkg::MODE_SETA) begin
            if (r_tick != '1) n_tick = r_tick + 32'd1;
            n_lvl = (r_lvl + 32'd1 >= lvl) ? 32'd0 : r_lvl + 32'd1;
        end
        unique case (r_mode) inside
            lrct_pkg::MODE_IDLE: begin
                v = lrct_pkg::gamma(r_tsel, 4'(lrct_pkg::ShadeTop));
                if (both) begin
                    hit = 1'b1;
                end else if (ad) begin
                    show = 1'b1;
                    if (r_lit < 5'(lrct_pkg::RingLeds)) begin
                        n_pix[r_lit[3:0]][7:0] = v;
                        n_lit = r_lit + 5'd1;
                    end else hit = 1'b1;
                end else if (st) begin
                    show = 1'b1; n_mul = 1'b1;
                    n_tick = '0; n_lvl = '0; n_shade = 4'(lrct_pkg::ShadeTop);
                    if (r_lit > 0) begin
                        n_mul_a = r_lit;
                        for (int i = 0; i < lrct_pkg::RingLeds; i++)
                            if (5'(i) < r_lit) n_pix[i] = {v, 16'd0};
                        n_lit = r_lit - 5'd1;
                        n_mode = lrct_pkg::MODE_DOWN;
                    end else begin
                        n_mul_a = 5'(lrct_pkg::RingLeds);
                        for (int i = 0; i < lrct_pkg::RingLeds; i++) n_pix[i] = '0;
                        n_mode = lrct_pkg::MODE_UP;
                    end
                end else if (lg) begin
                    show = 1'b1; n_tick = '0;
                    for (int i = 0; i < lrct_pkg::RingLeds; i++)
                        n_pix[i] = (i % 2 == 0) ? {8'd0, v, 8'd0} : '0;
                    n_mode = lrct_pkg::MODE_SETT;
                end
            end
            lrct_pkg::MODE_DOWN, lrct_pkg::MODE_UP: begin
                if ((r_mode == lrct_pkg::MODE_DOWN) ? both : st) hit = 1'b1;
                else if (n_lvl == '0) begin
                    if (r_lit < 5'(lrct_pkg::RingLeds)) begin
                        show = 1'b1;
                        n_shade = r_shade - 4'd1;
                        if (r_mode == lrct_pkg::MODE_DOWN) begin
                            n_pix[r_lit[3:0]][23:16] = lrct_pkg::gamma(r_tsel, n_shade);
                            if (n_shade == 0) begin
                                n_lit = r_lit - 5'd1;
                                n_shade = 4'(lrct_pkg::ShadeTop);
                            end
                        end else begin
                            n_pix[r_lit[3:0]][15:8] =
                                lrct_pkg::gamma(r_tsel, 4'(lrct_pkg::ShadeTop) - n_shade);
                            if (n_shade == 0) begin
                                n_lit = r_lit + 5'd1;
                                n_shade = 4'(lrct_pkg::ShadeTop);
                            end
                        end
                    end
                end else if (n_tick >= r_total) begin
                    if (r_mode == lrct_pkg::MODE_DOWN) begin
                        n_tick = '0; n_mode = lrct_pkg::MODE_ALERT;
                    end else hit = 1'b1;
                end
            end
            lrct_pkg::MODE_ALERT: begin
                if (both) hit = 1'b1;
                else if (st) begin
                    show = 1'b1; n_mul = 1'b1; n_mul_a = 5'(lrct_pkg::RingLeds);
                    for (int i = 0; i < lrct_pkg::RingLeds; i++) n_pix[i] = '0;
                    n_lit = '0; n_tick = '0; n_lvl = '0;
                    n_shade = 4'(lrct_pkg::ShadeTop); n_mode = lrct_pkg::MODE_UP;
                end else if (n_tick >= 32'(i_flash)) begin
                    v = lrct_pkg::gamma(r_asel, 4'(lrct_pkg::ShadeTop));
                    for (int i = 0; i < lrct_pkg::RingLeds; i++)
                        n_pix[i][23:16] = ((i % 2 == 1) == r_phase) ? v : 8'd0;
                    n_phase = !r_phase; n_tick = '0; show = 1'b1;
                end
            end
            lrct_pkg::MODE_SETT: begin
                if (both) begin
                    show = 1'b1; n_tick = '0;
                    v = lrct_pkg::gamma(r_asel, 4'(lrct_pkg::ShadeTop));
                    for (int i = 0; i < lrct_pkg::RingLeds; i++)
                        n_pix[i] = (i % 2 == 0) ? {v, 16'd0} : '0;
                    n_mode = lrct_pkg::MODE_SETA;
                end else if (n_tick >= i_tmo) hit = 1'b1;
                else if (ad || st) begin
                    show = 1'b1; n_tick = '0;
                    n_tsel = bump(r_tsel, ad);
                    v = lrct_pkg::gamma(n_tsel, 4'(lrct_pkg::ShadeTop));
                    for (int i = 0; i < lrct_pkg::RingLeds; i += 2) n_pix[i][15:8] = v;
                end
            end
            lrct_pkg::MODE_SETA: begin
                if (n_tick >= i_tmo || both) hit = 1'b1;
                else if (ad || st) begin
                    show = 1'b1; n_tick = '0;
                    n_asel = bump(r_asel, ad);
                    v = lrct_pkg::gamma(n_asel, 4'(lrct_pkg::ShadeTop));
                    for (int i = 0; i < lrct_pkg::RingLeds; i += 2) n_pix[i][23:16] = v;
                end
            end
            default: n_mode = lrct_pkg::MODE_IDLE;
        endcase
        // Return to idle: clear the ring and drop the lit count.
        if (hit) begin
            show = 1'b1; n_lit = '0; n_mode = lrct_pkg::MODE_IDLE;
            for (int i = 0; i < lrct_pkg::RingLeds; i++) n_pix[i] = '0;
        end
    end

    assign o_pop = (r_st == ST_RUN) && i_valid;
    assign o_busy = (r_st != ST_RUN);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_RUN: if (i_valid && show) n_st = n_mul ? ST_MUL : ST_OUT;
            ST_MUL: n_st = ST_OUT;
            ST_OUT: if (pix.ready && r_idx == 4'(lrct_pkg::RingLeds - 1)) n_st = ST_RUN;
            default: n_st = ST_RUN;
        endcase
    end

    assign pix.valid = (r_st == ST_OUT);
    assign pix.pixel_index = r_idx;
    assign pix.red_level = r_pix[r_idx][23:16];
    assign pix.green_level = r_pix[r_idx][15:8];
    assign pix.blue_level = r_pix[r_idx][7:0];
    assign pix.last_pixel = (r_idx == 4'(lrct_pkg::RingLeds - 1));
    assign pix.mode_now = r_mode;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_mul_a <= n_mul_a;
        if (!i_rst_n) begin
            r_st <= ST_RUN; r_mode <= lrct_pkg::MODE_IDLE; r_lit <= '0; r_shade <= '0;
            r_tick <= '0; r_lvl <= '0; r_tsel <= 5'd6; r_asel <= 5'd9; r_phase <= 1'b0;
            r_idx <= '0; r_total <= '0;
            for (int i = 0; i < lrct_pkg::RingLeds; i++) r_pix[i] <= '0;
        end else begin
            r_st <= n_st;
            if (o_pop) begin
                r_mode <= n_mode; r_lit <= n_lit; r_shade <= n_shade; r_tick <= n_tick;
                r_lvl <= n_lvl; r_tsel <= n_tsel; r_asel <= n_asel; r_phase <= n_phase;
                r_pix <= n_pix;
            end
            if (r_st == ST_MUL) r_total <= (prod[63:32] != '0) ? '1 : prod[31:0];
            if (r_st == ST_OUT && pix.ready)
                r_idx <= pix.last_pixel ? '0 : r_idx + 4'd1;
        end
    end
endmodule

@@ rtl/core/led_ring_countdown_timer.sv @@
// Top level of the LED ring countdown timer: config registers, tick queue, engine.
// Depends on lrct_pkg, lrct_if, lrct_queue, lrct_engine.
//
// channel   dir  beat
// tick_in   in   one timer tick: start, add, long-add flags
// pix_out   out  one pixel of the frame, last flagged
// cfg       in   one register write: index, 32-bit data
//
// A tick is decided combinationally; a tick that changes the ring emits 12 pixel
// beats, one a cycle while pix_out is ready, after a multiply state for the lit-count
// times ticks_per_led product when a count starts. The 4-deep tick queue takes ticks
// while a frame streams; output stalls hold the current pixel. Reset is synchronous:
// mode idle, ring dark, brightness rows six and nine, registers to defaults.
module led_ring_countdown_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrct_tick_if.sink   tick_in,
    lrct_pix_if.source  pix_out,
    lrct_cfg_if.sink    cfg
);
    logic [31:0] r_tpled, r_tmo;
    logic [28:0] r_tplvl;
    logic [15:0] r_flash;
    logic q_full, q_empty, pop, busy;
    lrct_pkg::t_tick q_in, q_out;

    // Hold configuration; writes must arrive only while idle, the block does not enforce it.
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpled <= 32'd500; r_tplvl <= 29'd62; r_flash <= 16'd100; r_tmo <= 32'd6000;
        end else if (cfg.valid) begin
            case (cfg.index)
                lrct_pkg::REG_TPLED: r_tpled <= cfg.data;
                lrct_pkg::REG_TPLVL: r_tplvl <= cfg.data[28:0];
                lrct_pkg::REG_FLASH: r_flash <= cfg.data[15:0];
                lrct_pkg::REG_TMO: r_tmo <= cfg.data;
                default: ;
            endcase
        end
    end

    // Front: queue incoming ticks.
    assign tick_in.ready = !q_full;
    assign q_in = '{start: tick_in.start_pressed, add: tick_in.add_pressed,
                    long_add: tick_in.add_long_pressed};

    lrct_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(tick_in.valid && !q_full), .i_data(q_in), .o_full(q_full),
        .i_pop(pop), .o_empty(q_empty), .o_data(q_out)
    );

    // Back: decide each tick and stream the frame.
    lrct_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(!q_empty), .i_tick(q_out), .o_pop(pop),
        .i_tpled(r_tpled), .i_tplvl(r_tplvl), .i_flash(r_flash), .i_tmo(r_tmo),
        .o_busy(busy), .pix(pix_out)
    );

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_out.valid && pix_out.last_pixel |-> pix_out.pixel_index == 4'd11)
        else $error("last pixel flag off position");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !pop)
        else $error("tick taken while frame in flight");
    a_mode_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_out.valid && $past(pix_out.valid) && $past(i_rst_n) |-> $stable(pix_out.mode_now))
        else $error("mode changed within a frame");
endmodule

@@ dv/tb_lrct_if.sv @@
`timescale 1ns / 1ps
// Testbench side of the tick, pixel and configuration channels.
// The bench instantiates the block's own interfaces from rtl/core/lrct_if.sv directly.

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for led_ring_countdown_timer: directed and random ticks, random output stalls.
// A timer predictor checks every pixel beat. Depends on lrct_pkg and lrct_if.

typedef struct packed {
    logic [3:0] idx;
    logic [7:0] r, g, b;
    logic       last;
    logic [2:0] md;
} t_frame_pix;

class ring_scoreboard;
    t_frame_pix pend_q[$];
    int         n_err;

    // State copy of the ring controller.
    logic [31:0] t_led, t_lvl, t_flash, t_tmo;
    logic [2:0]  md;
    logic [4:0]  lit, tsel, asel;
    logic [3:0]  shade;
    logic [31:0] tick_cnt, lvl_cnt, total;
    logic        phase;
    logic [7:0]  pr[12], pg[12], pb[12];

    function void reset_state();
        t_led = 500; t_lvl = 62; t_flash = 100; t_tmo = 6000;
        md = lrct_pkg::MODE_IDLE; lit = 0; shade = 0; tick_cnt = 0; lvl_cnt = 0; total = 0;
        tsel = 6; asel = 9; phase = 0;
        clear_ring();
        n_err = 0;
    endfunction

    function void clear_ring();
        for (int i = 0; i < 12; i++) begin
            pr[i] = 0; pg[i] = 0; pb[i] = 0;
        end
    endfunction

    function logic [7:0] shade_of(int row, int col);
        byte unsigned rom[17][9] = '{
            '{0,1,1,2,2,3,3,4,4}, '{0,1,2,3,4,5,6,7,8}, '{0,1,2,3,4,6,8,10,12},
            '{0,1,2,4,6,9,11,14,18}, '{0,1,2,4,7,10,15,20,26},
            '{0,1,3,5,9,14,20,27,35}, '{0,1,4,7,12,18,26,35,46},
            '{0,1,4,9,15,23,33,44,58}, '{0,1,3,8,15,25,38,54,73},
            '{0,1,4,9,18,30,46,65,89}, '{0,1,4,11,22,36,55,79,107},
            '{0,1,5,13,26,43,65,93,126}, '{0,1,6,16,30,50,76,109,148},
            '{0,1,7,18,35,58,89,127,172}, '{0,2,8,21,40,67,102,145,197},
            '{0,2,9,24,46,76,116,166,225}, '{0,2,11,27,52,87,132,188,255}};
        if (row > 16) row = 16;
        if (col > 8) col = 8;
        return rom[row][col];
    endfunction

    function logic [31:0] sat_product(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function void write_reg(logic [1:0] i, logic [31:0] d);
        case (i)
            lrct_pkg::REG_TPLED: t_led = d;
            lrct_pkg::REG_TPLVL: t_lvl = {3'b0, d[28:0]};
            lrct_pkg::REG_FLASH: t_flash = {16'b0, d[15:0]};
            lrct_pkg::REG_TMO:   t_tmo = d;
        endcase
    endfunction

    function void go_idle();
        lit = 0; clear_ring(); md = lrct_pkg::MODE_IDLE;
    endfunction

    function void start_count(logic [2:0] m);
        tick_cnt = 0; lvl_cnt = 0; shade = 8; md = m;
    endfunction

    function void enter_up();
        total = sat_product(12, t_led);
        clear_ring(); lit = 0;
        start_count(lrct_pkg::MODE_UP);
    endfunction

    function void paint_even(int ch, logic [7:0] v);
        for (int i = 0; i < 12; i += 2)
            if (ch == 0) pr[i] = v; else if (ch == 1) pg[i] = v; else pb[i] = v;
    endfunction

    function void step_bright(bit alert, bit up);
        int s;
        s = alert ? asel : tsel;
        if (s > 16) s = 16;
        if (up) s = (s + 1) % 17; else s = (s == 0) ? 16 : s - 1;
        if (alert) asel = 5'(s); else tsel = 5'(s);
        tick_cnt = 0;
        paint_even(alert ? 0 : 1, shade_of(s, 8));
    endfunction

    // Advance the predictor by one accepted tick and queue the frame it shows.
    function void note_tick(bit st, bit ad, bit lg);
        bit both, show;
        logic [31:0] lvl;
        t_frame_pix p;
        both = st && ad; show = 0;
        lvl = (t_lvl == 0) ? 1 : t_lvl;
        if (md >= 1 && md <= 5) begin
            if (tick_cnt != 32'hFFFF_FFFF) tick_cnt++;
            lvl_cnt = (lvl_cnt + 1 >= lvl) ? 0 : lvl_cnt + 1;
        end
        case (md)
            lrct_pkg::MODE_IDLE: begin
                if (both) begin go_idle(); show = 1; end
                else if (ad) begin
                    if (lit < 12) begin pb[lit] = shade_of(tsel, 8); lit++; end
                    else go_idle();
                    show = 1;
                end else if (st) begin
                    if (lit > 0) begin
                        total = sat_product(lit, t_led);
                        for (int i = 0; i < 12 && i < lit; i++) begin
                            pb[i] = 0; pr[i] = shade_of(tsel, 8);
                        end
                        lit = lit - 1;
                        start_count(lrct_pkg::MODE_DOWN);
                    end else enter_up();
                    show = 1;
                end else if (lg) begin
                    tick_cnt = 0; clear_ring(); paint_even(1, shade_of(tsel, 8));
                    md = lrct_pkg::MODE_SETT; show = 1;
                end
            end
            lrct_pkg::MODE_DOWN: begin
                if (both) begin go_idle(); show = 1; end
                else if (lvl_cnt == 0) begin
                    if (lit < 12) begin
                        shade = shade - 1;
                        pr[lit] = shade_of(tsel, shade);
                        if (shade == 0) begin lit = lit - 1; shade = 8; end
                        show = 1;
                    end
                end else if (tick_cnt >= total) begin
                    tick_cnt = 0; md = lrct_pkg::MODE_ALERT;
                end
            end
            lrct_pkg::MODE_ALERT: begin
                if (both) begin go_idle(); show = 1; end
                else if (st) begin enter_up(); show = 1; end
                else if (tick_cnt >= t_flash) begin
                    for (int i = 0; i < 12; i++)
                        pr[i] = ((i % 2 == 1) == phase) ? shade_of(asel, 8) : 8'd0;
                    phase = !phase; tick_cnt = 0; show = 1;
                end
            end
            lrct_pkg::MODE_UP: begin
                if (st) begin go_idle(); show = 1; end
                else if (lvl_cnt == 0) begin
                    if (lit < 12) begin
                        shade = shade - 1;
                        pg[lit] = shade_of(tsel, 4'(8 - shade));
                        if (shade == 0) begin lit++; shade = 8; end
                        show = 1;
                    end
                end else if (tick_cnt >= total) begin go_idle(); show = 1; end
            end
            lrct_pkg::MODE_SETT: begin
                if (both) begin
                    tick_cnt = 0; clear_ring(); paint_even(0, shade_of(asel, 8));
                    md = lrct_pkg::MODE_SETA; show = 1;
                end else if (tick_cnt >= t_tmo) begin go_idle(); show = 1; end
                else if (ad) begin step_bright(0, 1); show = 1; end
                else if (st) begin step_bright(0, 0); show = 1; end
            end
            lrct_pkg::MODE_SETA: begin
                if (tick_cnt >= t_tmo || both) begin go_idle(); show = 1; end
                else if (ad) begin step_bright(1, 1); show = 1; end
                else if (st) begin step_bright(1, 0); show = 1; end
            end
            default: md = lrct_pkg::MODE_IDLE;
        endcase
        if (show)
            for (int i = 0; i < 12; i++) begin
                p.idx = 4'(i); p.r = pr[i]; p.g = pg[i]; p.b = pb[i];
                p.last = (i == 11); p.md = md;
                pend_q.push_back(p);
            end
    endfunction

    function void check_pixel(t_frame_pix got);
        t_frame_pix want;
        if (pend_q.size() == 0) begin
            $display("%0t: unexpected pixel idx=%0d", $time, got.idx);
            n_err++;
            return;
        end
        want = pend_q.pop_front();
        if (got !== want) begin
            $display("%0t: pixel mismatch exp idx=%0d rgb=%0d/%0d/%0d last=%0b mode=%0d",
                     $time, want.idx, want.r, want.g, want.b, want.last, want.md);
            $display("%0t:                got idx=%0d rgb=%0d/%0d/%0d last=%0b mode=%0d",
                     $time, got.idx, got.r, got.g, got.b, got.last, got.md);
            n_err++;
        end
    endfunction
endclass

module tb_top;
    logic i_clk = 0;
    logic i_rst_n = 0;

    lrct_tick_if tick_ch();
    lrct_pix_if  pix_ch();
    lrct_cfg_if  cfg_ch();

    led_ring_countdown_timer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .tick_in(tick_ch.sink), .pix_out(pix_ch.source), .cfg(cfg_ch.sink)
    );

    ring_scoreboard sb;
    int tick_idle_pct;
    int pix_stall_pct;

    initial begin
        forever #5 i_clk = !i_clk;
    end

    // Hard stop: the slowest correct run is far below this.
    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: stall at random, check each accepted pixel beat.
    initial begin
        t_frame_pix got;
        pix_ch.ready <= 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
                got.idx = pix_ch.pixel_index; got.r = pix_ch.red_level;
                got.g = pix_ch.green_level; got.b = pix_ch.blue_level;
                got.last = pix_ch.last_pixel; got.md = pix_ch.mode_now;
                sb.check_pixel(got);
            end
            pix_ch.ready <= ($urandom_range(99) >= pix_stall_pct);
        end
    end

    // Send one tick beat; optionally idle the line for a random gap first.
    // Valid stays high after the beat until the next gap or drain drops it.
    task automatic send_tick(bit st, bit ad, bit lg);
        while ($urandom_range(99) < tick_idle_pct) begin
            tick_ch.valid <= 0;
            @(posedge i_clk);
        end
        tick_ch.valid <= 1;
        tick_ch.start_pressed <= st;
        tick_ch.add_pressed <= ad;
        tick_ch.add_long_pressed <= lg;
        do @(posedge i_clk); while (!tick_ch.ready);
        sb.note_tick(st, ad, lg);
    endtask

    // Wait until every queued pixel is out, then let the block settle.
    task automatic drain();
        int guard;
        guard = 0;
        tick_ch.valid <= 0;
        while (sb.pend_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] d);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, d);
    endtask

    task automatic set_regs(logic [31:0] led, logic [31:0] lvl, logic [31:0] fl,
                            logic [31:0] tmo);
        drain();
        write_cfg(lrct_pkg::REG_TPLED, led);
        write_cfg(lrct_pkg::REG_TPLVL, lvl);
        write_cfg(lrct_pkg::REG_FLASH, fl);
        write_cfg(lrct_pkg::REG_TMO, tmo);
        cfg_ch.valid <= 0;
    endtask

    // Random tick, weighted toward plain ticks so counts run their course.
    task automatic rand_tick();
        int k;
        k = $urandom_range(99);
        if (k < 70) send_tick(0, 0, 0);
        else if (k < 80) send_tick(0, 1, 0);
        else if (k < 86) send_tick(1, 0, 0);
        else if (k < 92) send_tick(0, 0, 1);
        else if (k < 96) send_tick(1, 1, 0);
        else send_tick($urandom_range(1), $urandom_range(1), $urandom_range(1));
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        tick_idle_pct = 15;
        pix_stall_pct = 56;
        tick_ch.valid <= 0;
        tick_ch.start_pressed <= 0;
        tick_ch.add_pressed <= 0;
        tick_ch.add_long_pressed <= 0;
        cfg_ch.valid <= 0;
        cfg_ch.index <= lrct_pkg::REG_TPLED;
        cfg_ch.data <= 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: fill past a full ring, clear, long press with bright steps.
        set_regs(16, 2, 3, 20);
        repeat (13) send_tick(0, 1, 0);
        send_tick(0, 1, 0);
        send_tick(1, 1, 0);
        send_tick(0, 0, 1);
        send_tick(0, 1, 0);
        send_tick(1, 0, 0);
        send_tick(1, 1, 0);
        send_tick(0, 1, 0);
        send_tick(1, 0, 0);
        send_tick(1, 1, 1);
        // Countup from empty and stop it, then start a countdown of two LEDs.
        send_tick(1, 0, 0);
        send_tick(1, 0, 0);
        send_tick(0, 1, 0);
        send_tick(0, 1, 0);
        send_tick(1, 0, 0);

        // Extremes: zero level means a step every tick, zero flash and timeout.
        set_regs(8, 0, 0, 0);
        repeat (30) rand_tick();
        set_regs(32'hFFFF_FFFF, 32'h1FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_tick(1, 1, 0);
        repeat (12) send_tick(0, 1, 0);
        send_tick(1, 0, 0);
        repeat (10) rand_tick();
        send_tick(1, 1, 0);

        // Random, three idle/stall phases.
        set_regs(24, 3, 5, 40);
        repeat (80) rand_tick();
        tick_idle_pct = 56;
        pix_stall_pct = 15;
        set_regs($urandom_range(8, 40), $urandom_range(1, 5), $urandom_range(1, 8),
                 $urandom_range(1, 60));
        repeat (80) rand_tick();
        tick_idle_pct = 0;
        pix_stall_pct = 0;
        set_regs(500, 62, 100, 6000);
        repeat (20) rand_tick();
        set_regs(16, 2, 4, 30);
        repeat (20) rand_tick();

        drain();
        if (sb.n_err == 0 && sb.pend_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
